// ===== hdl/gic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gic_pkg
// Shared widths, register indexes, quadrant codes and types for the gamepad
// input conditioner.
// ----------------------------------------------------------------------------
package gic_pkg;

    localparam int BUTTON_BITS = 16;
    localparam int BTN_W       = 16;
    localparam int AXIS_W      = 16;
    localparam int CFG_W       = 16;
    localparam int TIMER_W     = 16;
    localparam int CFG_IDX_W   = 1;

    // Only the low BUTTON_BITS bits of the button word are used.
    localparam logic [BTN_W-1:0] BUTTON_MASK = (BUTTON_BITS >= BTN_W) ? {BTN_W{1'b1}} :
        BTN_W'((64'd1 << BUTTON_BITS) - 64'd1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GESTURE_WINDOW = 1'b1;

    // Q15 value of 1.0: the largest useful smoothing coefficient.
    localparam logic [CFG_W-1:0] ALPHA_ONE    = 16'h8000;
    localparam logic [CFG_W-1:0] ALPHA_RESET  = 16'd3277;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 16'd100;

    // Left-stick quadrant codes, in clockwise gesture order.
    localparam logic [1:0] QUAD_PP = 2'd0;
    localparam logic [1:0] QUAD_PN = 2'd1;
    localparam logic [1:0] QUAD_NN = 2'd2;
    localparam logic [1:0] QUAD_NP = 2'd3;

    typedef logic signed [AXIS_W-1:0] t_axis;
    typedef logic [1:0]               t_quadrant;

    typedef struct packed {
        t_quadrant          quadrant;
        logic [TIMER_W-1:0] timer;
    } t_gesture;

endpackage
`default_nettype wire

// ===== hdl/gamepad_input_conditioner_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_input_conditioner_top
// Conditions controller polls: button press and release edges, Q15
// exponential smoothing of four stick axes, and a quadrant rotation gesture.
//
//   channel   handshake                 payload
//   -------   -----------------------   -------------------------------------
//   input     i_in_valid / o_in_stall   connected, buttons, four stick axes
//   output    o_out_valid / i_out_stall pressed, released, smoothed axes,
//                                       rotation_done
//   config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A request is registered on entry and its result is computed into the state
// registers, which double as the output register; one request can be taken
// every cycle while the output is not stalled.
// Reset clears the state, loads the register defaults and empties both stages.
// While the output is stalled, one more request is held in the input stage.
// ----------------------------------------------------------------------------
module gamepad_input_conditioner_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_connected,
    input  wire logic [gic_pkg::BTN_W-1:0]         i_buttons,
    input  wire gic_pkg::t_axis                    i_left_x,
    input  wire gic_pkg::t_axis                    i_left_y,
    input  wire gic_pkg::t_axis                    i_right_x,
    input  wire gic_pkg::t_axis                    i_right_y,

    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [gic_pkg::BTN_W-1:0]              o_pressed,
    output logic [gic_pkg::BTN_W-1:0]              o_released,
    output gic_pkg::t_axis                         o_smooth_left_x,
    output gic_pkg::t_axis                         o_smooth_left_y,
    output gic_pkg::t_axis                         o_smooth_right_x,
    output gic_pkg::t_axis                         o_smooth_right_y,
    output logic                                   o_rotation_done,

    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [gic_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [gic_pkg::CFG_W-1:0]         i_cfg_data
);
    import gic_pkg::*;

    // Configuration.
    logic [CFG_W-1:0] r_alpha;
    logic [CFG_W-1:0] r_window;
    logic [CFG_W-1:0] alpha_sat;

    // Input stage.
    logic             r_in_valid;
    logic             r_in_connected;
    logic [BTN_W-1:0] r_in_buttons;
    t_axis            r_in_axes [4];

    // State, also the output register.
    logic             r_out_valid;
    logic [BTN_W-1:0] r_prev_buttons;
    logic [BTN_W-1:0] r_pressed;
    logic [BTN_W-1:0] r_released;
    t_axis            r_filt [4];
    t_gesture         r_gesture;

    logic             n_out_valid;
    logic [BTN_W-1:0] now_buttons;
    t_axis            n_filt [4];
    t_gesture         n_gesture;
    logic             advance;
    logic             update;

    assign o_cfg_ready = 1'b1;
    assign alpha_sat   = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= ALPHA_RESET;
            r_window <= WINDOW_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FILTER_ALPHA:   r_alpha  <= i_cfg_data;
                CFG_GESTURE_WINDOW: r_window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The output stage moves when it is empty or being taken.
    assign advance     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !advance;
    assign update      = r_in_valid && advance && r_in_connected;
    assign n_out_valid = advance ? r_in_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_connected <= i_connected;
            r_in_buttons   <= i_buttons;
            r_in_axes[0]   <= i_left_x;
            r_in_axes[1]   <= i_left_y;
            r_in_axes[2]   <= i_right_x;
            r_in_axes[3]   <= i_right_y;
        end
    end

    assign now_buttons = r_in_buttons & BUTTON_MASK;

    for (genvar k = 0; k < 4; k++) begin : g_axis
        gic_axis_filter u_filter (
            .i_alpha  (alpha_sat),
            .i_filt   (r_filt[k]),
            .i_sample (r_in_axes[k]),
            .o_next   (n_filt[k])
        );
    end

    gic_gesture u_gesture (
        .i_lx     (r_in_axes[0]),
        .i_ly     (r_in_axes[1]),
        .i_window (r_window),
        .i_state  (r_gesture),
        .o_state  (n_gesture)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid        <= 1'b0;
            r_prev_buttons     <= '0;
            r_pressed          <= '0;
            r_released         <= '0;
            r_filt[0]          <= '0;
            r_filt[1]          <= '0;
            r_filt[2]          <= '0;
            r_filt[3]          <= '0;
            r_gesture.quadrant <= QUAD_PP;
            r_gesture.timer    <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            // A disconnected poll leaves the state alone and repeats it.
            if (update) begin
                r_pressed      <= ~r_prev_buttons & now_buttons;
                r_released     <= r_prev_buttons & ~now_buttons;
                r_prev_buttons <= now_buttons;
                r_filt[0]      <= n_filt[0];
                r_filt[1]      <= n_filt[1];
                r_filt[2]      <= n_filt[2];
                r_filt[3]      <= n_filt[3];
                r_gesture      <= n_gesture;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pressed        = r_pressed;
    assign o_released       = r_released;
    assign o_smooth_left_x  = r_filt[0];
    assign o_smooth_left_y  = r_filt[1];
    assign o_smooth_right_x = r_filt[2];
    assign o_smooth_right_y = r_filt[3];
    assign o_rotation_done  = (r_gesture.quadrant == QUAD_NP);

endmodule
`default_nettype wire

// ===== hdl/gic_axis_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gic_axis_filter
// One axis of the exponential smoother: f + round(alpha * (x - f)) in Q15,
// rounded half up and saturated to the 16-bit signed range.
// ----------------------------------------------------------------------------
module gic_axis_filter (
    input  wire logic [gic_pkg::CFG_W-1:0] i_alpha,
    input  wire gic_pkg::t_axis            i_filt,
    input  wire gic_pkg::t_axis            i_sample,
    output gic_pkg::t_axis                 o_next
);
    import gic_pkg::*;

    logic signed [AXIS_W:0]     diff;
    logic signed [2*AXIS_W+1:0] prod;
    logic signed [2*AXIS_W+1:0] rounded;
    logic signed [2*AXIS_W+1:0] shifted;
    logic signed [AXIS_W+2:0]   sum;

    assign diff    = $signed({i_sample[AXIS_W-1], i_sample}) - $signed({i_filt[AXIS_W-1], i_filt});
    assign prod    = $signed({1'b0, i_alpha}) * diff;
    assign rounded = prod + (2*AXIS_W+2)'(16384);
    assign shifted = rounded >>> 15;
    assign sum     = $signed({{3{i_filt[AXIS_W-1]}}, i_filt}) + $signed(shifted[AXIS_W+2:0]);

    always_comb begin
        if (sum > $signed((AXIS_W+3)'(32767))) begin
            o_next = 16'sh7FFF;
        end else if (sum < -$signed((AXIS_W+3)'(32768))) begin
            o_next = 16'sh8000;
        end else begin
            o_next = sum[AXIS_W-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/gic_gesture.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gic_gesture
// Next state of the clockwise left-stick quadrant gesture for one connected
// poll: a stick in the first quadrant rearms the window timer, and the gesture
// falls back to the first quadrant once the timer has run out.
// ----------------------------------------------------------------------------
module gic_gesture (
    input  wire gic_pkg::t_axis              i_lx,
    input  wire gic_pkg::t_axis              i_ly,
    input  wire logic [gic_pkg::CFG_W-1:0]   i_window,
    input  wire gic_pkg::t_gesture           i_state,
    output gic_pkg::t_gesture                o_state
);
    import gic_pkg::*;

    logic x_pos;
    logic x_neg;
    logic y_pos;
    logic y_neg;

    assign x_neg = i_lx[AXIS_W-1];
    assign y_neg = i_ly[AXIS_W-1];
    assign x_pos = !x_neg && (i_lx != '0);
    assign y_pos = !y_neg && (i_ly != '0);

    always_comb begin
        o_state = i_state;
        if (x_pos && y_pos) begin
            o_state.quadrant = QUAD_PP;
            o_state.timer    = i_window;
        end
        if (o_state.timer != '0) begin
            o_state.timer = o_state.timer - TIMER_W'(1);
            // A finished rotation starts over, and may step on in the same poll.
            if (o_state.quadrant == QUAD_NP) begin
                o_state.quadrant = QUAD_PP;
            end
            if (x_pos && !y_pos && o_state.quadrant == QUAD_PP) begin
                o_state.quadrant = QUAD_PN;
            end
            if (!x_pos && y_neg && o_state.quadrant == QUAD_PN) begin
                o_state.quadrant = QUAD_NN;
            end
            if (x_neg && !y_neg && o_state.quadrant == QUAD_NN) begin
                o_state.quadrant = QUAD_NP;
            end
        end else begin
            o_state.quadrant = QUAD_PP;
        end
    end

endmodule
`default_nettype wire
